### hdl/kruskal_mst_weight_defines.svh
// Assertion macros shared by the minimum spanning tree weight block.
`ifndef KRUSKAL_MST_WEIGHT_DEFINES_SVH
`define KRUSKAL_MST_WEIGHT_DEFINES_SVH
`ifndef SYNTHESIS
`define KMW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kmw: same-cycle check failed");
`define KMW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kmw: next-cycle check failed");
`else
`define KMW_ASSERT_NOW(label, clk, rst, ante, cons)
`define KMW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/kmw_pkg.sv
// Types, constants and helpers for the minimum spanning tree weight block.
`default_nettype none
package kmw_pkg;
   localparam int MAX_NODES_DEF   = 256;
   localparam int MAX_EDGES_DEF   = 1024;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int NODE_BITS       = 8;
   localparam int NODE_IDS        = 256;
   localparam int CFG_BITS        = 9;
   localparam int NCNT_BITS       = 13;
   localparam int QUEUE_DEPTH     = 2;
   localparam int TOTAL_BITS      = 24;
   localparam logic [CFG_BITS-1:0] NODE_COUNT_RST = 9'd256;

   typedef struct packed {
      logic [7:0]  node_u;
      logic [7:0]  node_v;
      logic [15:0] edge_weight;
      logic        last_edge;
   } req_type;

   typedef struct packed {
      logic [23:0] total_weight;
      logic [7:0]  edges_taken;
      logic        spanning;
      logic        dropped_edge;
   } rsp_type;

   // Zero counts as one node, anything above the maximum as the maximum.
   function automatic logic [NCNT_BITS-1:0] clamp_nodes(input logic [CFG_BITS-1:0] c,
                                                        input int unsigned maxn);
      logic [NCNT_BITS-1:0] r;
      if (c == '0) r = NCNT_BITS'(1);
      else if (32'(c) > maxn) r = NCNT_BITS'(maxn);
      else r = NCNT_BITS'(c);
      return r;
   endfunction
endpackage
`default_nettype wire

### hdl/kmw_front.sv
// Front end: range check of an incoming edge and packing into a queue word.
`default_nettype none
module kmw_front #(
   parameter int MAX_NODES   = kmw_pkg::MAX_NODES_DEF,
   parameter int WEIGHT_BITS = kmw_pkg::WEIGHT_BITS_DEF,
   parameter int QW          = 2 + 2 * kmw_pkg::NODE_BITS + WEIGHT_BITS
) (
   input  wire kmw_pkg::req_type               req_item,
   input  wire logic [kmw_pkg::CFG_BITS-1:0]   node_count,
   output logic [QW-1:0]                       q_wdata
);
   logic [kmw_pkg::NCNT_BITS-1:0] n;
   logic [WEIGHT_BITS-1:0]        w;
   logic                          bad;

   always_comb begin
      n = kmw_pkg::clamp_nodes(node_count, MAX_NODES);
      bad = (kmw_pkg::NCNT_BITS'(req_item.node_u) >= n) ||
            (kmw_pkg::NCNT_BITS'(req_item.node_v) >= n);
      w = '0;
      for (int i = 0; i < WEIGHT_BITS; i++) begin
         if (i < 16) w[i] = req_item.edge_weight[i];
      end
      // word: last, drop, u, v, weight
      q_wdata = {req_item.last_edge, bad, req_item.node_u, req_item.node_v, w};
   end
endmodule
`default_nettype wire

### hdl/kmw_queue.sv
// Short queue between the front end and the solver.
`default_nettype none
module kmw_queue #(
   parameter int QW = 34
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_push,
   input  wire logic [QW-1:0] q_wdata,
   output logic               q_full,
   input  wire logic          q_pop,
   output logic               q_empty,
   output logic [QW-1:0]      q_rdata
);
   localparam int D  = kmw_pkg::QUEUE_DEPTH;
   localparam int PW = (D > 1) ? $clog2(D) : 1;
   localparam int CW = $clog2(D + 1);

   logic [QW-1:0] slot_ff [D];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   always_comb begin
      q_full  = (cnt_ff == CW'(D));
      q_empty = (cnt_ff == '0);
      q_rdata = slot_ff[rp_ff];
      do_push = q_push && !q_full;
      do_pop  = q_pop && !q_empty;
      wp_in   = do_push ? ((wp_ff == PW'(D - 1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in   = do_pop ? ((rp_ff == PW'(D - 1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in  = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wp_ff] <= q_wdata;
   end
endmodule
`default_nettype wire

### hdl/kmw_back.sv
// Solver: edge store, weight-ordered scans and union-find walks.
`default_nettype none
`include "kruskal_mst_weight_defines.svh"
module kmw_back #(
   parameter int MAX_NODES   = kmw_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES   = kmw_pkg::MAX_EDGES_DEF,
   parameter int WEIGHT_BITS = kmw_pkg::WEIGHT_BITS_DEF,
   parameter int QW          = 2 + 2 * kmw_pkg::NODE_BITS + WEIGHT_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [kmw_pkg::CFG_BITS-1:0] node_count,
   input  wire logic [QW-1:0]                q_rdata,
   input  wire logic                         q_empty,
   output logic                              q_pop,
   input  wire logic                         pop,
   output logic                              rsp_vld,
   output kmw_pkg::rsp_type                  rsp_item
);
   localparam int NB  = kmw_pkg::NODE_BITS;
   localparam int EW  = 2 * NB + WEIGHT_BITS;
   localparam int ETW = $clog2(MAX_EDGES + 1);
   localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int NCW = $clog2(MAX_NODES + 1);
   localparam int NW  = $clog2(MAX_NODES);
   localparam int XW  = kmw_pkg::NCNT_BITS;

   localparam logic [2:0] ST_LOAD = 3'd0;
   localparam logic [2:0] ST_INIT = 3'd1;
   localparam logic [2:0] ST_RD   = 3'd2;
   localparam logic [2:0] ST_CHK  = 3'd3;
   localparam logic [2:0] ST_FA   = 3'd4;
   localparam logic [2:0] ST_FB   = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [EW-1:0]          store_mem [MAX_EDGES];
   logic [NB-1:0]          par_mem [kmw_pkg::NODE_IDS];
   logic [kmw_pkg::NODE_IDS-1:0] pv_ff;

   logic [2:0]             state_ff, state_in;
   logic [ETW-1:0]         etot_ff, etot_in;
   logic                   drop_ff, drop_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [WEIGHT_BITS-1:0] cur_ff, cur_in, nxt_ff, nxt_in;
   logic                   first_ff, first_in, hasn_ff, hasn_in;
   logic [23:0]            acc_ff, acc_in;
   logic [NW-1:0]          taken_ff, taken_in;
   logic [NB-1:0]          x_ff, x_in, ru_ff, ru_in;
   logic                   phase_ff, phase_in;
   logic [NCW-1:0]         n_ff, n_in;
   logic [EW-1:0]          e_ff;
   logic [NB-1:0]          pd_ff;
   logic                   rsp_vld_ff, rsp_vld_in;
   kmw_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   st_we, p_we, clr, adv, has_v, last_idx;
   logic [WEIGHT_BITS-1:0] nxt_v, ew;
   logic [NB-1:0]          eu, ev, p;
   logic [32:0]            sum;
   logic                   in_rng;
   logic [NCW-1:0]         taken_x;

   always_comb begin
      state_in = state_ff;  etot_in = etot_ff;   drop_in = drop_ff;
      idx_in = idx_ff;      cur_in = cur_ff;     nxt_in = nxt_ff;
      first_in = first_ff;  hasn_in = hasn_ff;   acc_in = acc_ff;
      taken_in = taken_ff;  x_in = x_ff;         ru_in = ru_ff;
      phase_in = phase_ff;  n_in = n_ff;         rsp_vld_in = rsp_vld_ff;
      rsp_in = rsp_ff;
      q_pop = 1'b0;  st_we = 1'b0;  p_we = 1'b0;  clr = 1'b0;  adv = 1'b0;
      has_v = hasn_ff;  nxt_v = nxt_ff;
      {eu, ev, ew} = e_ff;
      in_rng = (XW'(eu) < XW'(n_ff)) && (XW'(ev) < XW'(n_ff));
      p = pv_ff[x_ff] ? pd_ff : x_ff;
      sum = 33'(acc_ff) + 33'(ew);
      last_idx = ((ETW'(idx_ff) + ETW'(1)) == etot_ff);
      taken_x = NCW'(taken_ff);

      if (pop && rsp_vld_ff) rsp_vld_in = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (!q_rdata[QW-2] && (etot_ff < ETW'(MAX_EDGES))) begin
                  st_we = 1'b1;
                  etot_in = etot_ff + ETW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (q_rdata[QW-1]) begin
                  n_in = NCW'(kmw_pkg::clamp_nodes(node_count, MAX_NODES));
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            clr = 1'b1;
            first_in = 1'b1;
            hasn_in = 1'b0;
            acc_in = '0;
            taken_in = '0;
            idx_in = '0;
            state_in = (etot_ff == '0) ? ST_DONE : ST_RD;
         end
         ST_RD: state_in = ST_CHK;
         ST_CHK: begin
            // track the smallest weight above the current one (any weight on the first scan) for the next scan
            if ((first_ff || ew > cur_ff) && (!hasn_ff || ew < nxt_ff)) begin
               has_v = 1'b1;
               nxt_v = ew;
            end
            hasn_in = has_v;
            nxt_in = nxt_v;
            if (!first_ff && ew == cur_ff && in_rng) begin
               x_in = eu;
               phase_in = 1'b0;
               state_in = ST_FA;
            end else begin
               adv = 1'b1;
            end
         end
         ST_FA: state_in = ST_FB;
         ST_FB: begin
            if (p != x_ff) begin
               x_in = p;
               state_in = ST_FA;
            end else if (!phase_ff) begin
               ru_in = x_ff;
               x_in = ev;
               phase_in = 1'b1;
               state_in = ST_FA;
            end else begin
               if (ru_ff != x_ff) begin
                  p_we = 1'b1;
                  acc_in = (sum > 33'(24'hFFFFFF)) ? 24'hFFFFFF : sum[23:0];
                  taken_in = taken_ff + NW'(1);
               end
               adv = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff) begin
               rsp_in.total_weight = acc_ff;
               rsp_in.edges_taken = (taken_x > NCW'(255)) ? 8'hFF : 8'(taken_x);
               rsp_in.spanning = (taken_x == n_ff - NCW'(1));
               rsp_in.dropped_edge = drop_ff;
               rsp_vld_in = 1'b1;
               etot_in = '0;
               drop_in = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase

      if (adv) begin
         if (last_idx) begin
            if (has_v) begin
               cur_in = nxt_v;
               first_in = 1'b0;
               hasn_in = 1'b0;
               idx_in = '0;
               state_in = ST_RD;
            end else begin
               state_in = ST_DONE;
            end
         end else begin
            idx_in = idx_ff + AW'(1);
            state_in = ST_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         etot_ff <= '0;
         drop_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         pv_ff <= '0;
      end else begin
         state_ff <= state_in;
         etot_ff <= etot_in;
         drop_ff <= drop_in;
         rsp_vld_ff <= rsp_vld_in;
         if (clr) pv_ff <= '0;
         else if (p_we) pv_ff[ru_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;    cur_ff <= cur_in;     nxt_ff <= nxt_in;
      first_ff <= first_in; hasn_ff <= hasn_in;  acc_ff <= acc_in;
      taken_ff <= taken_in; x_ff <= x_in;        ru_ff <= ru_in;
      phase_ff <= phase_in; n_ff <= n_in;        rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) store_mem[etot_ff[AW-1:0]] <= q_rdata[EW-1:0];
      e_ff <= store_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (p_we) par_mem[ru_ff] <= x_ff;
      pd_ff <= par_mem[x_ff];
   end

   assign rsp_vld = rsp_vld_ff;
   assign rsp_item = rsp_ff;

   `KMW_ASSERT_NOW(a_etot_bound, clock, reset, 1'b1, etot_ff <= ETW'(MAX_EDGES))
   `KMW_ASSERT_NOW(a_pop_in_load, clock, reset, q_pop, state_ff == ST_LOAD)
   `KMW_ASSERT_NEXT(a_done_posts, clock, reset, state_ff == ST_DONE && !rsp_vld_ff, rsp_vld_ff && state_ff == ST_LOAD)
   `KMW_ASSERT_NOW(a_union_roots, clock, reset, p_we, ru_ff != x_ff && !pv_ff[ru_ff])
endmodule
`default_nettype wire

### hdl/kruskal_mst_weight.sv
// Top level of the minimum spanning forest weight block.
// Input side: a queue port. Drive req_item and push; the edge word is taken
// on a clock edge with push high and full low. Up to two words sit in the
// inner queue; while the solver is loading it drains one word per cycle, so
// edges load back to back. A word with last_edge set closes the graph.
// Result side: a queue port. While empty is low rsp_item holds the result of
// the oldest closed graph; pop with empty low takes it.
// Solve steps after the closing word leaves the queue: a setup state, one scan
// of the store to find the lowest weight and one more per distinct weight, a
// read and a check state per stored edge on each scan, a read and a step state
// per node visited on each of the two root walks of an in-range edge of the
// scanned weight, and a state to post the result; empty drops the cycle after.
// The single read ports of the edge and parent memories set the read states.
// While a graph is solved, and while a solved graph waits behind an untaken
// result, the inner queue fills and full holds the input.
// node_count is written through csr_wr_en/csr_wr_data; the user must write
// it only while the block is idle, the block does not enforce that. Reset
// empties queue and store, drops any pending result and sets node_count to 256.
`default_nettype none
module kruskal_mst_weight #(
   parameter int MAX_NODES   = kmw_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES   = kmw_pkg::MAX_EDGES_DEF,
   parameter int WEIGHT_BITS = kmw_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire kmw_pkg::req_type             req_item,
   input  wire logic                         push,
   output logic                              full,
   output kmw_pkg::rsp_type                  rsp_item,
   output logic                              empty,
   input  wire logic                         pop,
   input  wire logic                         csr_wr_en,
   input  wire logic [kmw_pkg::CFG_BITS-1:0] csr_wr_data
);
   localparam int QW = 2 + 2 * kmw_pkg::NODE_BITS + WEIGHT_BITS;

   logic [kmw_pkg::CFG_BITS-1:0] node_count_ff, node_count_in;
   logic [QW-1:0] q_wdata, q_rdata;
   logic          q_empty, q_pop, rsp_vld;

   assign node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) node_count_ff <= kmw_pkg::NODE_COUNT_RST;
      else node_count_ff <= node_count_in;
   end

   kmw_front #(.MAX_NODES(MAX_NODES), .WEIGHT_BITS(WEIGHT_BITS), .QW(QW)) u_front (
      .req_item(req_item), .node_count(node_count_ff), .q_wdata(q_wdata)
   );

   kmw_queue #(.QW(QW)) u_queue (
      .clock(clock), .reset(reset), .q_push(push), .q_wdata(q_wdata), .q_full(full),
      .q_pop(q_pop), .q_empty(q_empty), .q_rdata(q_rdata)
   );

   kmw_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS),
              .QW(QW)) u_back (
      .clock(clock), .reset(reset), .node_count(node_count_ff), .q_rdata(q_rdata),
      .q_empty(q_empty), .q_pop(q_pop), .pop(pop), .rsp_vld(rsp_vld), .rsp_item(rsp_item)
   );

   assign empty = !rsp_vld;
endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the minimum spanning forest weight block.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 1024;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   kmw_pkg::req_type req_item = '0;
   logic push = 1'b0;
   logic full;
   kmw_pkg::rsp_type rsp_item;
   logic empty;
   logic pop = 1'b0;
   logic csr_wr_en = 1'b0;
   logic [kmw_pkg::CFG_BITS-1:0] csr_wr_data = '0;

   kruskal_mst_weight dut (
      .clock(clock), .reset(reset), .req_item(req_item), .push(push), .full(full),
      .rsp_item(rsp_item), .empty(empty), .pop(pop),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: graph being collected and the node count register
   logic [7:0]  graph_u[$];
   logic [7:0]  graph_v[$];
   logic [15:0] graph_w[$];
   bit          graph_dropped;
   logic [kmw_pkg::CFG_BITS-1:0] node_reg = kmw_pkg::NODE_COUNT_RST;

   kmw_pkg::rsp_type forest_expected[$];
   int errors = 0;
   int graphs_closed = 0;
   int graphs_with_drops = 0;
   int edges_sent = 0;
   int stall_pct = 0;
   int long_hold = 0;
   longint cycle_count = 0;

   typedef struct {
      bit                           is_cfg;
      logic [kmw_pkg::CFG_BITS-1:0] cfg_value;
      kmw_pkg::req_type             word;
      bit                           typed;
      kmw_pkg::rsp_type             want;
   } stim_row;

   stim_row rows[$];

   function automatic int active_nodes();
      int n;
      n = int'(node_reg);
      if (n < 1) n = 1;
      if (n > 256) n = 256;
      return n;
   endfunction

   function automatic int find_root(ref int parent[256], input int x);
      while (parent[x] != x) x = parent[x];
      return x;
   endfunction

   // sort stored edges by weight and grow the forest
   function automatic kmw_pkg::rsp_type solve_forest();
      int parent[256];
      int tsize[256];
      int n, target, taken, ra, rb, t, j;
      longint sum;
      logic [7:0] ku, kv;
      logic [15:0] kw;
      kmw_pkg::rsp_type r;
      n = active_nodes();
      for (int i = 0; i < 256; i++) begin
         parent[i] = i;
         tsize[i] = 1;
      end
      for (int i = 1; i < graph_w.size(); i++) begin
         ku = graph_u[i]; kv = graph_v[i]; kw = graph_w[i];
         j = i;
         while (j > 0 && graph_w[j-1] > kw) begin
            graph_u[j] = graph_u[j-1]; graph_v[j] = graph_v[j-1]; graph_w[j] = graph_w[j-1];
            j--;
         end
         graph_u[j] = ku; graph_v[j] = kv; graph_w[j] = kw;
      end
      target = n - 1;
      taken = 0;
      sum = 0;
      for (int i = 0; i < graph_w.size(); i++) begin
         if (taken >= target) break;
         if (graph_u[i] >= n || graph_v[i] >= n) continue;
         ra = find_root(parent, graph_u[i]);
         rb = find_root(parent, graph_v[i]);
         if (ra == rb) continue;
         if (tsize[ra] < tsize[rb]) begin
            t = ra; ra = rb; rb = t;
         end
         parent[rb] = ra;
         tsize[ra] += tsize[rb];
         sum += graph_w[i];
         if (sum > 64'd16777215) sum = 16777215;
         taken++;
      end
      r.total_weight = sum[23:0];
      r.edges_taken = (taken > 255) ? 8'd255 : taken[7:0];
      r.spanning = (taken == target);
      r.dropped_edge = graph_dropped;
      graph_u.delete(); graph_v.delete(); graph_w.delete();
      graph_dropped = 0;
      return r;
   endfunction

   // offer one edge word, hold it until taken, then update the predictor
   task automatic send_edge(input kmw_pkg::req_type e, input int idle_pct, input bit typed,
                            input kmw_pkg::rsp_type typed_rsp);
      int n;
      kmw_pkg::rsp_type r;
      while ($urandom_range(99) < idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_item <= e;
      do @(posedge clock); while (full);
      edges_sent++;
      n = active_nodes();
      if (e.node_u >= n || e.node_v >= n || graph_w.size() >= STORE_DEPTH) begin
         graph_dropped = 1;
      end else begin
         graph_u.insert(graph_u.size(), e.node_u);
         graph_v.insert(graph_v.size(), e.node_v);
         graph_w.insert(graph_w.size(), e.edge_weight);
      end
      if (e.last_edge) begin
         r = solve_forest();
         forest_expected.insert(forest_expected.size(), typed ? typed_rsp : r);
         graphs_closed++;
         if (r.dropped_edge) graphs_with_drops++;
      end
   endtask

   task automatic drain_results();
      push <= 1'b0;
      @(posedge clock);
      while (forest_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [kmw_pkg::CFG_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      node_reg = value;
   endtask

   function automatic kmw_pkg::req_type mk_edge(input int u, input int v, input int w,
                                                input bit last);
      kmw_pkg::req_type e;
      e.node_u = u[7:0];
      e.node_v = v[7:0];
      e.edge_weight = w[15:0];
      e.last_edge = last;
      return e;
   endfunction

   function automatic kmw_pkg::rsp_type mk_rsp(input int w, input int taken, input bit span,
                                               input bit drop);
      kmw_pkg::rsp_type r;
      r.total_weight = w[23:0];
      r.edges_taken = taken[7:0];
      r.spanning = span;
      r.dropped_edge = drop;
      return r;
   endfunction

   task automatic add_row(input bit is_cfg, input logic [kmw_pkg::CFG_BITS-1:0] cfg_value,
                          input kmw_pkg::req_type word, input bit typed,
                          input kmw_pkg::rsp_type want);
      stim_row r;
      r.is_cfg = is_cfg;
      r.cfg_value = cfg_value;
      r.word = word;
      r.typed = typed;
      r.want = want;
      rows.insert(rows.size(), r);
   endtask

   // result side: pop at random, check each accepted word
   initial begin
      kmw_pkg::rsp_type want;
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            if (forest_expected.size() == 0) begin
               $error("result word with nothing expected: %p", rsp_item);
               errors++;
            end else begin
               want = forest_expected.pop_front();
               if (rsp_item.total_weight !== want.total_weight) begin
                  $error("total_weight expected %0d got %0d", want.total_weight,
                         rsp_item.total_weight);
                  errors++;
               end
               if (rsp_item.edges_taken !== want.edges_taken) begin
                  $error("edges_taken expected %0d got %0d", want.edges_taken,
                         rsp_item.edges_taken);
                  errors++;
               end
               if (rsp_item.spanning !== want.spanning) begin
                  $error("spanning expected %0d got %0d", want.spanning, rsp_item.spanning);
                  errors++;
               end
               if (rsp_item.dropped_edge !== want.dropped_edge) begin
                  $error("dropped_edge expected %0d got %0d", want.dropped_edge,
                         rsp_item.dropped_edge);
                  errors++;
               end
            end
         end
         if (reset) begin
            pop <= 1'b0;
         end else if (long_hold > 0) begin
            long_hold--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      int idle_pct, hi, phase_items, k, u, v, w;
      int idle_mode[4] = '{0, 58, 0, 32};
      int stall_mode[4] = '{0, 0, 58, 32};
      logic [kmw_pkg::CFG_BITS-1:0] phase_cfg[8] = '{9'd256, 9'd16, 9'd1, 9'd200,
                                                     9'd256, 9'd3, 9'd511, 9'd64};

      // directed table; typed results where obvious, otherwise predicted
      add_row(0, 0, mk_edge(0, 1, 5, 1), 1, mk_rsp(5, 1, 0, 0));
      add_row(0, 0, mk_edge(255, 0, 65535, 1), 1, mk_rsp(65535, 1, 0, 0));
      add_row(0, 0, mk_edge(7, 7, 9, 1), 1, mk_rsp(0, 0, 0, 0));
      add_row(0, 0, mk_edge(0, 1, 4, 0), 0, '0);
      add_row(0, 0, mk_edge(1, 2, 4, 0), 0, '0);
      add_row(0, 0, mk_edge(0, 2, 1, 0), 0, '0);
      add_row(0, 0, mk_edge(2, 3, 65535, 1), 0, '0);
      add_row(1, 9'd2, '0, 0, '0);
      add_row(0, 0, mk_edge(0, 1, 3, 0), 0, '0);
      add_row(0, 0, mk_edge(0, 5, 1, 1), 1, mk_rsp(3, 1, 1, 1));
      add_row(0, 0, mk_edge(5, 6, 1, 1), 1, mk_rsp(0, 0, 0, 1));
      // node count lowered while edges sit in the store
      add_row(1, 9'd256, '0, 0, '0);
      add_row(0, 0, mk_edge(10, 11, 2, 0), 0, '0);
      add_row(0, 0, mk_edge(0, 1, 3, 0), 0, '0);
      add_row(1, 9'd4, '0, 0, '0);
      add_row(0, 0, mk_edge(1, 2, 5, 1), 1, mk_rsp(8, 2, 0, 0));
      add_row(1, 9'd0, '0, 0, '0);
      add_row(0, 0, mk_edge(0, 0, 7, 1), 1, mk_rsp(0, 0, 1, 0));
      add_row(1, 9'd511, '0, 0, '0);
      add_row(0, 0, mk_edge(255, 254, 1, 1), 1, mk_rsp(1, 1, 0, 0));
      add_row(1, 9'd256, '0, 0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].is_cfg) begin
            drain_results();
            write_node_count(rows[i].cfg_value);
         end else begin
            send_edge(rows[i].word, 0, rows[i].typed, rows[i].want);
         end
      end

      // fill the store past its depth: a full chain of weight 1, then heavier edges
      stall_pct = 20;
      for (int i = 0; i < STORE_DEPTH + 1; i++) begin
         if (i < 255) send_edge(mk_edge(i, i + 1, 1, 0), 10, 0, '0);
         else send_edge(mk_edge($urandom_range(255), $urandom_range(255), 2, 0), 10, 0, '0);
      end
      send_edge(mk_edge(3, 4, 1, 1), 0, 0, '0);
      drain_results();

      for (int ph = 0; ph < 8; ph++) begin
         write_node_count(phase_cfg[ph]);
         idle_pct = idle_mode[ph % 4];
         stall_pct = stall_mode[ph % 4];
         // hold off results so the block backs up into its input
         if (ph == 1) long_hold = 4000;
         hi = active_nodes() - 1;
         phase_items = 0;
         while (phase_items < 20) begin
            k = $urandom_range(8, 1);
            for (int e = 0; e < k; e++) begin
               if ($urandom_range(11) == 0) begin
                  u = $urandom_range(255);
                  v = $urandom_range(255);
               end else begin
                  u = $urandom_range(hi);
                  v = $urandom_range(hi);
               end
               w = (ph % 2) ? $urandom_range(7) : ($urandom & 16'hffff);
               send_edge(mk_edge(u, v, w, e == k - 1), idle_pct, 0, '0);
               phase_items++;
            end
         end
         drain_results();
      end

      $display("sent %0d edge words in %0d graphs, %0d graphs with dropped edges",
               edges_sent, graphs_closed, graphs_with_drops);
      $display("covered node count extremes, store overflow and four idle/stall mixes");
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
`default_nettype wire
